// ===== rtl/sbfd_pkg.sv =====
// Package for the sync byte frame deframer.
// Holds frame geometry constants and the decoded frame field struct.
// No dependencies.
package sbfd_pkg;

	localparam int FRAME_BYTES = 32;
	localparam int STORE_DEPTH = FRAME_BYTES - 2;
	localparam int COUNT_W     = $clog2(FRAME_BYTES);

	localparam logic [7:0]         SYNC_RESET = 8'hA5;
	localparam logic [COUNT_W-1:0] LAST_INDEX = COUNT_W'(FRAME_BYTES - 1);

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [31:0] speed_word;
		logic [7:0]  duty_byte;
		logic [31:0] current_word;
		logic [31:0] voltage_word;
		logic [31:0] power_word;
		logic [31:0] gain_p_word;
		logic [31:0] gain_i_word;
		logic [31:0] gain_d_word;
		logic [7:0]  mode_byte;
	} frame_fields_t;

	typedef struct packed {
		logic in_frame;
		logic last_byte;
		logic good;
	} frame_status_t;

endpackage

// ===== rtl/sbfd_core.sv =====
// Frame tracker: sync hunt, byte counter, running XOR and the frame byte shift line.
// Decodes the stored bytes into the result fields; status.good flags a good checksum.
// Depends on sbfd_pkg.
module sbfd_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_en,
	input  sbfd_pkg::byte_t        byte_in,
	input  sbfd_pkg::byte_t        sync_value,
	output sbfd_pkg::frame_status_t status,
	output sbfd_pkg::frame_fields_t fields
);

	logic                         in_frame_q;
	logic [sbfd_pkg::COUNT_W-1:0] count_q;
	sbfd_pkg::byte_t              xor_q;
	sbfd_pkg::byte_t              store_q [sbfd_pkg::STORE_DEPTH];

	logic data_byte;

	always_comb begin
		status.in_frame  = in_frame_q;
		status.last_byte = in_frame_q && (count_q == sbfd_pkg::LAST_INDEX);
		status.good      = status.last_byte && (byte_in == xor_q);
		data_byte        = in_frame_q && (count_q != sbfd_pkg::LAST_INDEX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			xor_q      <= '0;
		end else if (byte_en) begin
			if (!in_frame_q) begin
				if (byte_in == sync_value) begin
					in_frame_q <= 1'b1;
					count_q    <= sbfd_pkg::COUNT_W'(1);
					xor_q      <= byte_in;
				end
			end else if (data_byte) begin
				count_q <= count_q + sbfd_pkg::COUNT_W'(1);
				xor_q   <= xor_q ^ byte_in;
			end else begin
				in_frame_q <= 1'b0;
				count_q    <= '0;
				xor_q      <= '0;
			end
		end
	end

	// shift frame bytes 1..30 down so byte 1 lands at entry 0
	always_ff @(posedge clk) begin
		if (byte_en && data_byte) begin
			for (int i = 0; i < sbfd_pkg::STORE_DEPTH - 1; i++) begin
				store_q[i] <= store_q[i+1];
			end
			store_q[sbfd_pkg::STORE_DEPTH-1] <= byte_in;
		end
	end

	always_comb begin
		fields.speed_word   = {store_q[3], store_q[2], store_q[1], store_q[0]};
		fields.duty_byte    = store_q[4];
		fields.current_word = {store_q[8], store_q[7], store_q[6], store_q[5]};
		fields.voltage_word = {store_q[12], store_q[11], store_q[10], store_q[9]};
		fields.power_word   = {store_q[16], store_q[15], store_q[14], store_q[13]};
		fields.gain_p_word  = {store_q[20], store_q[19], store_q[18], store_q[17]};
		fields.gain_i_word  = {store_q[24], store_q[23], store_q[22], store_q[21]};
		fields.gain_d_word  = {store_q[28], store_q[27], store_q[26], store_q[25]};
		fields.mode_byte    = store_q[29];
	end

`ifndef ASSERT_OFF
	a_hunt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (count_q == '0) && (xor_q == '0))
		else $error("hunting with nonzero count or xor");

	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (count_q != '0))
		else $error("in frame with zero count");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		byte_en && status.last_byte |=> !in_frame_q)
		else $error("frame not closed after checksum byte");
`endif

endmodule

// ===== rtl/sync_byte_frame_deframer_xor.sv =====
// Top level of the sync byte frame deframer with XOR checksum.
// Input register, frame tracker (sbfd_core) and result register.
// Depends on sbfd_pkg and sbfd_core.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | rx_byte
//  out     | out_valid / out_stall | speed_word .. mode_byte (nine fields)
//  config  | cfg_wr_en             | cfg_wr_data (sync value)
//
// One byte per cycle while the input is not stalled. A byte waits in the input register;
// the edge that feeds it to the frame tracker also loads a good frame's result into
// the result register. Reset clears the hunt state and sets the sync value to 0xA5.
// A stalled result holds; the input side stalls only when the byte in hand closes a
// good frame and the result is stuck.
module sync_byte_frame_deframer_xor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] speed_word,
	output logic [7:0]  duty_byte,
	output logic [31:0] current_word,
	output logic [31:0] voltage_word,
	output logic [31:0] power_word,
	output logic [31:0] gain_p_word,
	output logic [31:0] gain_i_word,
	output logic [31:0] gain_d_word,
	output logic [7:0]  mode_byte
);

	sbfd_pkg::byte_t         sync_q;
	logic                    valid_s1;
	sbfd_pkg::byte_t         byte_s1;
	logic                    valid_s2;
	sbfd_pkg::frame_fields_t res_s2;

	sbfd_pkg::frame_status_t status;
	sbfd_pkg::frame_fields_t fields;
	logic                    advance;
	logic                    load_res;

	always_comb begin
		advance  = valid_s1 && (!status.good || !valid_s2 || !out_stall);
		load_res = advance && status.good;
		in_stall = valid_s1 && !advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= sbfd_pkg::SYNC_RESET;
		end else if (cfg_wr_en) begin
			sync_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	sbfd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_en    (advance),
		.byte_in    (byte_s1),
		.sync_value (sync_q),
		.status     (status),
		.fields     (fields)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_res) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_s2 <= fields;
		end
	end

	always_comb begin
		out_valid    = valid_s2;
		speed_word   = res_s2.speed_word;
		duty_byte    = res_s2.duty_byte;
		current_word = res_s2.current_word;
		voltage_word = res_s2.voltage_word;
		power_word   = res_s2.power_word;
		gain_p_word  = res_s2.gain_p_word;
		gain_i_word  = res_s2.gain_i_word;
		gain_d_word  = res_s2.gain_d_word;
		mode_byte    = res_s2.mode_byte;
	end

`ifndef ASSERT_OFF
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && status.good && valid_s2)
		else $error("input stalled without a blocked result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(load_res))
		else $error("result appeared without a good frame");

	a_good_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		status.good |-> status.in_frame)
		else $error("checksum match outside a frame");
`endif

endmodule

// ===== sim/sync_byte_frame_deframer_xor_tb.sv =====
// Self-checking testbench for sync_byte_frame_deframer_xor: sends byte streams of noise,
// good, corrupted and cut-short frames under random idling and checks each decoded frame.
// Depends on sbfd_pkg and the deframer RTL.
`timescale 1ns / 100ps

module sync_byte_frame_deframer_xor_tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] speed_word;
	logic [7:0]  duty_byte;
	logic [31:0] current_word;
	logic [31:0] voltage_word;
	logic [31:0] power_word;
	logic [31:0] gain_p_word;
	logic [31:0] gain_i_word;
	logic [31:0] gain_d_word;
	logic [7:0]  mode_byte;

	sbfd_pkg::frame_fields_t      pending_frames[$];
	sbfd_pkg::byte_t              sync_byte;
	logic                         in_frame_m;
	logic [sbfd_pkg::COUNT_W-1:0] byte_idx;
	sbfd_pkg::byte_t              xor_acc;
	sbfd_pkg::byte_t              frame_bytes [1:sbfd_pkg::STORE_DEPTH];
	sbfd_pkg::byte_t              frame_buf [0:sbfd_pkg::FRAME_BYTES-1];
	bit                           idle_on;
	int                           fail_count;
	int                           stall_left;

	sync_byte_frame_deframer_xor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.speed_word   (speed_word),
		.duty_byte    (duty_byte),
		.current_word (current_word),
		.voltage_word (voltage_word),
		.power_word   (power_word),
		.gain_p_word  (gain_p_word),
		.gain_i_word  (gain_i_word),
		.gain_d_word  (gain_d_word),
		.mode_byte    (mode_byte)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("[sync_byte_frame_deframer_xor] ERROR");
		$finish;
	end

	function automatic logic [31:0] word_from(int pos);
		return {frame_bytes[pos+3], frame_bytes[pos+2], frame_bytes[pos+1], frame_bytes[pos]};
	endfunction

	function automatic void track_frame_byte(sbfd_pkg::byte_t b);
		sbfd_pkg::frame_fields_t f;
		if (!in_frame_m) begin
			if (b == sync_byte) begin
				in_frame_m = 1'b1;
				byte_idx   = sbfd_pkg::COUNT_W'(1);
				xor_acc    = b;
			end
		end else if (byte_idx != sbfd_pkg::LAST_INDEX) begin
			frame_bytes[byte_idx] = b;
			xor_acc ^= b;
			byte_idx++;
		end else begin
			in_frame_m = 1'b0;
			byte_idx   = '0;
			if (b == xor_acc) begin
				f.speed_word   = word_from(1);
				f.duty_byte    = frame_bytes[5];
				f.current_word = word_from(6);
				f.voltage_word = word_from(10);
				f.power_word   = word_from(14);
				f.gain_p_word  = word_from(18);
				f.gain_i_word  = word_from(22);
				f.gain_d_word  = word_from(26);
				f.mode_byte    = frame_bytes[30];
				pending_frames.push_back(f);
			end
			xor_acc = '0;
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	initial begin
		sbfd_pkg::frame_fields_t f;
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_frames.size() == 0) begin
					$display("%0t frame expected none actual speed %h mode %h",
						$time, speed_word, mode_byte);
					fail_count++;
				end else begin
					f = pending_frames.pop_front();
					check_field("speed_word", f.speed_word, speed_word);
					check_field("duty_byte", {24'h000000, f.duty_byte},
						{24'h000000, duty_byte});
					check_field("current_word", f.current_word, current_word);
					check_field("voltage_word", f.voltage_word, voltage_word);
					check_field("power_word", f.power_word, power_word);
					check_field("gain_p_word", f.gain_p_word, gain_p_word);
					check_field("gain_i_word", f.gain_i_word, gain_i_word);
					check_field("gain_d_word", f.gain_d_word, gain_d_word);
					check_field("mode_byte", {24'h000000, f.mode_byte},
						{24'h000000, mode_byte});
				end
				stall_left = idle_on ? $urandom_range(0, 11) : 0;
			end
			@(posedge clk);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(sbfd_pkg::byte_t b);
		int gap;
		bit taken;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		track_frame_byte(b);
	endtask

	task automatic send_part(int first, int last);
		for (int i = first; i <= last; i++)
			send_byte(frame_buf[i]);
	endtask

	// fill sync and checksum around the payload in frame_buf[1..30]
	task automatic build_frame(bit corrupt);
		sbfd_pkg::byte_t x;
		frame_buf[0] = sync_byte;
		x = sync_byte;
		for (int i = 1; i <= sbfd_pkg::STORE_DEPTH; i++)
			x ^= frame_buf[i];
		frame_buf[sbfd_pkg::FRAME_BYTES-1] =
			corrupt ? x ^ sbfd_pkg::byte_t'($urandom_range(1, 255)) : x;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_sync(sbfd_pkg::byte_t v);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sync_byte = v;
	endtask

	task automatic test_frame_extremes();
		idle_on = 1'b1;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(~sbfd_pkg::SYNC_RESET);
		for (int i = 1; i <= sbfd_pkg::STORE_DEPTH; i++)
			frame_buf[i] = 8'h00;
		build_frame(1'b0);
		send_part(0, sbfd_pkg::FRAME_BYTES - 1);
		for (int i = 1; i <= sbfd_pkg::STORE_DEPTH; i++)
			frame_buf[i] = 8'hFF;
		build_frame(1'b0);
		send_part(0, sbfd_pkg::FRAME_BYTES - 1);
	endtask

	task automatic test_sync_in_payload();
		for (int i = 1; i <= sbfd_pkg::STORE_DEPTH; i++)
			frame_buf[i] = sync_byte;
		build_frame(1'b0);
		send_part(0, sbfd_pkg::FRAME_BYTES - 1);
		for (int i = 1; i <= sbfd_pkg::STORE_DEPTH; i++)
			frame_buf[i] = (i % 3 == 0) ? sync_byte : sbfd_pkg::byte_t'($urandom);
		build_frame(1'b1);
		send_part(0, sbfd_pkg::FRAME_BYTES - 1);
		for (int i = 1; i <= sbfd_pkg::STORE_DEPTH; i++)
			frame_buf[i] = sbfd_pkg::byte_t'($urandom);
		build_frame(1'b0);
		send_part(0, sbfd_pkg::FRAME_BYTES - 1);
	endtask

	task automatic test_midframe_sync_write();
		for (int i = 1; i <= sbfd_pkg::STORE_DEPTH; i++)
			frame_buf[i] = sbfd_pkg::byte_t'($urandom);
		build_frame(1'b0);
		send_part(0, 10);
		set_sync(8'h3C);
		send_part(11, sbfd_pkg::FRAME_BYTES - 1);
		send_byte(sbfd_pkg::SYNC_RESET);
		for (int i = 1; i <= sbfd_pkg::STORE_DEPTH; i++)
			frame_buf[i] = sbfd_pkg::byte_t'($urandom);
		build_frame(1'b0);
		send_part(0, sbfd_pkg::FRAME_BYTES - 1);
	endtask

	task automatic test_random_frames(sbfd_pkg::byte_t v, int n_frames, bit idle_mode);
		int kind;
		set_sync(v);
		for (int n = 0; n < n_frames; n++) begin
			idle_on = idle_mode && ($urandom_range(0, 3) != 0);
			if (n == n_frames / 2)
				wait_idle();
			repeat ($urandom_range(0, 2)) send_byte(sbfd_pkg::byte_t'($urandom));
			for (int i = 1; i <= sbfd_pkg::STORE_DEPTH; i++)
				frame_buf[i] = sbfd_pkg::byte_t'($urandom);
			kind = $urandom_range(0, 99);
			build_frame(kind >= 80 && kind < 92);
			if (kind >= 92)
				send_part(0, $urandom_range(1, sbfd_pkg::STORE_DEPTH));
			else
				send_part(0, sbfd_pkg::FRAME_BYTES - 1);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 8'h00;
		in_valid    = 1'b0;
		rx_byte     = 8'h00;
		idle_on     = 1'b0;
		fail_count  = 0;
		sync_byte   = sbfd_pkg::SYNC_RESET;
		in_frame_m  = 1'b0;
		byte_idx    = '0;
		xor_acc     = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_frame_extremes();
		test_sync_in_payload();
		test_midframe_sync_write();
		test_random_frames(8'h00, 8, 1'b0);
		test_random_frames(8'hFF, 7, 1'b1);
		test_random_frames(sbfd_pkg::byte_t'($urandom), 7, 1'b1);
		test_random_frames(sbfd_pkg::SYNC_RESET, 8, 1'b1);

		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[sync_byte_frame_deframer_xor] OK");
		else
			$display("[sync_byte_frame_deframer_xor] ERROR");
		$finish;
	end

endmodule
